[rtl/lce_pkg.sv]
package lce_pkg;

	// Default sizes of the tree.
	localparam int COORD_BITS_DEF = 10;
	localparam int NODE_COUNT_DEF = 2048;

	// Fixed field widths.
	localparam int SLOPE_W   = 16;
	localparam int ICPT_W    = 32;
	localparam int RESULT_W  = 34;
	localparam int REQ_W     = 2;
	localparam int CFG_IDX_W = 2;

	// Request kinds.
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SEG   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_MAX    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_HIGH = 2'd2;

	// Magnitude of the value that an empty path folds in.
	localparam logic signed [ICPT_W-1:0] SENTINEL_MAG = 32'sd2000000000;

	// One entry of the node store.
	typedef struct packed {
		logic                      valid;
		logic signed [SLOPE_W-1:0] slope;
		logic signed [ICPT_W-1:0]  intercept;
	} node_t;

endpackage

[rtl/lce_node_store.sv]
module lce_node_store #(
	parameter int NODE_COUNT = lce_pkg::NODE_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
	input  lce_pkg::node_t                wr_data,
	input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
	output lce_pkg::node_t                rd_data
);
	import lce_pkg::*;

	node_t mem [NODE_COUNT];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/li_chao_line_envelope_core.sv]
// Li Chao tree that keeps the lower (mode_max 0) or upper (mode_max 1) envelope of
// lines y = line_slope * x + line_intercept over the configured x domain
// [domain_low, domain_high]. One request is taken at a time and gives exactly one
// result: the best line value at point_x for a query, zero for every other
// request. A query that meets an empty node folds in -2e9 or +2e9, the sentinel of
// the current mode, and a query on an inverted domain answers that sentinel. All
// work runs on one shared multiply-add unit and one node store (one write port,
// one read port), so the work of a request grows with the tree depth D (about
// COORD_BITS + 1 levels): a query steps through S_QRD, S_QCHK and S_QACC at each
// level, a full-domain add through S_FRD to S_FDEC at each level (one memory read
// and four line evaluations at each node), and a segment add visits up to about
// 2 nodes per level plus the full adds that it starts below them. A clear request
// sweeps every node of the memory; the same clearing pass runs after reset, and no
// request is accepted until it finishes (configuration writes are taken during it).
// Configuration must only be written while the block is idle. A finished result
// sits in an output register, so the next request may be accepted while it waits.
module li_chao_line_envelope_core #(
	parameter int COORD_BITS = lce_pkg::COORD_BITS_DEF,
	parameter int NODE_COUNT = lce_pkg::NODE_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [lce_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lce_pkg::REQ_W-1:0]           req_type,
	input  logic signed [lce_pkg::SLOPE_W-1:0]  line_slope,
	input  logic signed [lce_pkg::ICPT_W-1:0]   line_intercept,
	input  logic signed [COORD_BITS-1:0]        seg_left,
	input  logic signed [COORD_BITS-1:0]        seg_right,
	input  logic signed [COORD_BITS-1:0]        point_x,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lce_pkg::RESULT_W-1:0] best_value
);
	import lce_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int XW   = CW + 1;                 // internal coordinate width
	localparam int AW   = $clog2(NODE_COUNT);     // memory address width
	localparam int IW   = AW + 1;                 // node index, may pass the store
	localparam int PW   = SLOPE_W + XW;           // product width
	localparam int EW   = (PW + 1 > RESULT_W) ? PW + 1 : RESULT_W;
	localparam int STK_D = CW + 2;                // pending right children
	localparam int SKW  = $clog2(STK_D);
	localparam int SPW  = $clog2(STK_D + 1);

	// Sequencer states. The F states run the full-domain insert at one node,
	// the Q states walk a query and the S states walk a segment add.
	typedef enum logic [14:0] {
		S_IDLE  = 15'h0001,
		S_CLR   = 15'h0002,
		S_FRD   = 15'h0004,
		S_FCHK  = 15'h0008,
		S_FOL   = 15'h0010,
		S_FNM   = 15'h0020,
		S_FOM   = 15'h0040,
		S_FDEC  = 15'h0080,
		S_QRD   = 15'h0100,
		S_QCHK  = 15'h0200,
		S_QACC  = 15'h0400,
		S_SNODE = 15'h0800,
		S_SCHK  = 15'h1000,
		S_SPOP  = 15'h2000,
		S_FIN   = 15'h4000
	} state_t;

	state_t state_q;

	logic                       mode_q;
	logic signed [CW-1:0]       dom_lo_q, dom_hi_q;
	logic                       in_seg_q, clr_resp_q;
	logic signed [SLOPE_W-1:0]  cur_s_q, old_s_q, line_s_q;
	logic signed [ICPT_W-1:0]   cur_c_q, old_c_q, line_c_q;
	logic signed [XW-1:0]       ql_q, qr_q, x_q, l_q, r_q;
	logic [IW-1:0]              idx_q;
	logic signed [EW-1:0]       ev_q, evp_q, acc_q;
	logic                       win_l_q, have_q;
	logic [RESULT_W-1:0]        res_q;
	logic [SPW-1:0]             sp_q;
	logic [IW-1:0]              stk_idx_q [STK_D];
	logic signed [XW-1:0]       stk_l_q [STK_D];
	logic signed [XW-1:0]       stk_r_q [STK_D];
	logic [AW-1:0]              clr_cnt_q;
	logic                       out_valid_q;
	logic [RESULT_W-1:0]        best_q;

	node_t                      wr_data, rd_data;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;

	logic signed [XW-1:0]       diff, mid, mid_p1;
	logic signed [SLOPE_W-1:0]  u_s;
	logic signed [ICPT_W-1:0]   u_c;
	logic signed [XW-1:0]       u_x;
	logic signed [PW-1:0]       u_prod;
	logic signed [EW-1:0]       u_sum;
	logic signed [EW-1:0]       sent_ev, fold_sent, fold_ev;
	logic signed [ICPT_W-1:0]   sent_c;
	logic                       win_m, beyond, seg_out, seg_full;
	logic [IW-1:0]              idx_l, idx_r;
	logic [SPW-1:0]             sp_dec;
	state_t                     full_next;
	logic                       accept;

	function automatic logic better_f(input logic mx, input logic signed [EW-1:0] a,
			input logic signed [EW-1:0] b);
		return mx ? (a > b) : (a < b);
	endfunction

	// Midpoint of the current node's range; r is never below l here.
	assign diff   = r_q - l_q;
	assign mid    = l_q + (diff >>> 1);
	assign mid_p1 = mid + XW'(1);

	assign idx_l  = {idx_q[IW-2:0], 1'b0};
	assign idx_r  = {idx_q[IW-2:0], 1'b1};
	assign beyond = (idx_q >= IW'(NODE_COUNT));
	assign sp_dec = sp_q - SPW'(1);

	assign sent_ev = mode_q ? -EW'(SENTINEL_MAG) : EW'(SENTINEL_MAG);
	assign sent_c  = mode_q ? -SENTINEL_MAG : SENTINEL_MAG;

	// Shared line evaluation unit: slope * x + intercept, registered in ev_q.
	always_comb begin
		u_s = cur_s_q;
		u_c = cur_c_q;
		u_x = l_q;
		case (state_q)
			S_FOL: begin
				u_s = old_s_q;
				u_c = old_c_q;
			end
			S_FNM: begin
				u_x = mid;
			end
			S_FOM: begin
				u_s = old_s_q;
				u_c = old_c_q;
				u_x = mid;
			end
			S_QCHK: begin
				u_s = rd_data.slope;
				u_c = rd_data.intercept;
				u_x = x_q;
			end
			default: begin
			end
		endcase
	end

	assign u_prod = PW'(u_s) * PW'(u_x);
	assign u_sum  = EW'(u_prod) + EW'(u_c);

	// ev_q holds the old line at the midpoint and evp_q the new one in S_FDEC.
	assign win_m = better_f(mode_q, evp_q, ev_q);

	assign fold_sent = (!have_q || better_f(mode_q, sent_ev, acc_q)) ? sent_ev : acc_q;
	assign fold_ev   = (!have_q || better_f(mode_q, ev_q, acc_q)) ? ev_q : acc_q;

	assign seg_out  = beyond || (l_q > qr_q) || (r_q < ql_q);
	assign seg_full = (l_q >= ql_q) && (r_q <= qr_q);

	assign full_next = in_seg_q ? S_SPOP : S_FIN;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign best_value = best_q;

	// Node store write port.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = '{valid: 1'b1, slope: cur_s_q, intercept: cur_c_q};
		case (state_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
			end
			S_FCHK: begin
				wr_en = !rd_data.valid;
			end
			S_FDEC: begin
				wr_en = win_m;
			end
			S_SCHK: begin
				wr_en   = !rd_data.valid;
				wr_data = '{valid: 1'b1, slope: '0, intercept: sent_c};
			end
			default: begin
			end
		endcase
	end

	lce_node_store #(
		.NODE_COUNT(NODE_COUNT)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			dom_lo_q <= {1'b1, {(CW-1){1'b0}}};
			dom_hi_q <= {1'b0, {(CW-1){1'b1}}};
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MODE_MAX:    mode_q   <= cfg_data[0];
				CFG_DOMAIN_LOW:  dom_lo_q <= cfg_data;
				CFG_DOMAIN_HIGH: dom_hi_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		ev_q  <= u_sum;
		evp_q <= ev_q;
		if (state_q == S_SCHK) begin
			stk_idx_q[sp_q[SKW-1:0]] <= idx_r;
			stk_l_q[sp_q[SKW-1:0]]   <= mid_p1;
			stk_r_q[sp_q[SKW-1:0]]   <= r_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_resp_q  <= 1'b0;
			clr_cnt_q   <= '0;
			in_seg_q    <= 1'b0;
			have_q      <= 1'b0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
			best_q      <= '0;
			res_q       <= '0;
			cur_s_q     <= '0;
			cur_c_q     <= '0;
			old_s_q     <= '0;
			old_c_q     <= '0;
			line_s_q    <= '0;
			line_c_q    <= '0;
			ql_q        <= '0;
			qr_q        <= '0;
			x_q         <= '0;
			l_q         <= '0;
			r_q         <= '0;
			idx_q       <= '0;
			acc_q       <= '0;
			win_l_q     <= 1'b0;
		end else begin
			// In S_FIN the output register is reloaded instead of emptied.
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q    <= '0;
						idx_q    <= IW'(1);
						l_q      <= XW'(dom_lo_q);
						r_q      <= XW'(dom_hi_q);
						cur_s_q  <= line_slope;
						cur_c_q  <= line_intercept;
						line_s_q <= line_slope;
						line_c_q <= line_intercept;
						ql_q     <= XW'(seg_left);
						qr_q     <= XW'(seg_right);
						x_q      <= XW'(point_x);
						have_q   <= 1'b0;
						sp_q     <= '0;
						in_seg_q <= (req_type == REQ_SEG);
						if (req_type == REQ_CLEAR) begin
							clr_cnt_q  <= '0;
							clr_resp_q <= 1'b1;
							state_q    <= S_CLR;
						end else if (dom_lo_q > dom_hi_q) begin
							if (req_type == REQ_QUERY) begin
								res_q <= sent_ev[RESULT_W-1:0];
							end
							state_q <= S_FIN;
						end else if (req_type == REQ_ADD) begin
							state_q <= S_FRD;
						end else if (req_type == REQ_SEG) begin
							state_q <= S_SNODE;
						end else begin
							state_q <= S_QRD;
						end
					end
				end
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(NODE_COUNT - 1)) begin
						state_q <= clr_resp_q ? S_FIN : S_IDLE;
					end
				end
				S_FRD: begin
					state_q <= beyond ? full_next : S_FCHK;
				end
				S_FCHK: begin
					old_s_q <= rd_data.slope;
					old_c_q <= rd_data.intercept;
					state_q <= rd_data.valid ? S_FOL : full_next;
				end
				S_FOL: begin
					state_q <= S_FNM;
				end
				S_FNM: begin
					win_l_q <= better_f(mode_q, evp_q, ev_q);
					state_q <= S_FOM;
				end
				S_FOM: begin
					state_q <= S_FDEC;
				end
				S_FDEC: begin
					// The loser at the midpoint goes on down toward the side
					// where it may still win.
					if (win_m) begin
						cur_s_q <= old_s_q;
						cur_c_q <= old_c_q;
					end
					if (l_q == r_q) begin
						state_q <= full_next;
					end else begin
						if (win_l_q != win_m) begin
							idx_q <= idx_l;
							r_q   <= mid;
						end else begin
							idx_q <= idx_r;
							l_q   <= mid_p1;
						end
						state_q <= S_FRD;
					end
				end
				S_QRD: begin
					if (beyond) begin
						res_q   <= fold_sent[RESULT_W-1:0];
						state_q <= S_FIN;
					end else begin
						state_q <= S_QCHK;
					end
				end
				S_QCHK: begin
					if (!rd_data.valid) begin
						res_q   <= fold_sent[RESULT_W-1:0];
						state_q <= S_FIN;
					end else begin
						state_q <= S_QACC;
					end
				end
				S_QACC: begin
					acc_q  <= fold_ev;
					have_q <= 1'b1;
					if (l_q == r_q) begin
						res_q   <= fold_ev[RESULT_W-1:0];
						state_q <= S_FIN;
					end else begin
						if (x_q <= mid) begin
							idx_q <= idx_l;
							r_q   <= mid;
						end else begin
							idx_q <= idx_r;
							l_q   <= mid_p1;
						end
						state_q <= S_QRD;
					end
				end
				S_SNODE: begin
					if (seg_out) begin
						state_q <= S_SPOP;
					end else if (seg_full) begin
						cur_s_q <= line_s_q;
						cur_c_q <= line_c_q;
						state_q <= S_FRD;
					end else begin
						state_q <= S_SCHK;
					end
				end
				S_SCHK: begin
					// Partly covered node: the right child waits on the stack.
					sp_q    <= sp_q + SPW'(1);
					idx_q   <= idx_l;
					r_q     <= mid;
					state_q <= S_SNODE;
				end
				S_SPOP: begin
					if (sp_q == '0) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= stk_idx_q[sp_dec[SKW-1:0]];
						l_q     <= stk_l_q[sp_dec[SKW-1:0]];
						r_q     <= stk_r_q[sp_dec[SKW-1:0]];
						sp_q    <= sp_dec;
						state_q <= S_SNODE;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						best_q      <= res_q;
						clr_resp_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/lce_checker.sv]
module lce_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [lce_pkg::REQ_W-1:0]           req_type,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [lce_pkg::RESULT_W-1:0] best_value
);
	import lce_pkg::*;

	logic [REQ_W-1:0] pend_req_q, shown_req_q;

	// The kind of the request in flight moves to the output side when the
	// output register may take a new result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_req_q  <= REQ_ADD;
			shown_req_q <= REQ_ADD;
		end else begin
			if (in_valid && in_ready) begin
				pend_req_q <= req_type;
			end
			if (!out_valid || out_ready) begin
				shown_req_q <= pend_req_q;
			end
		end
	end

	// A waiting result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_value))
		else $error("result changed while stalled");

	// Requests are worked one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// Only a query answers a nonzero value.
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (shown_req_q != REQ_QUERY) |-> best_value == '0)
		else $error("nonzero result for a non-query request");

endmodule

bind li_chao_line_envelope_core lce_checker u_lce_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the Li Chao line envelope core.
// An initial block builds requests into a pending queue, grouped in phases.
// Each phase has its own idle pattern and register setting. A clocked driver
// presents the requests on the input channel, and a clocked monitor compares
// every result with the oldest value in the queue of predicted answers.
// Prediction runs when a request is accepted. It keeps a private copy of the
// node store and of the registers and mirrors the tree walk exactly.
module tb_top;
	import lce_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int NC = NODE_COUNT_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint SENT = 64'sd2000000000;

	typedef struct packed {
		logic [REQ_W-1:0]          kind;
		logic signed [SLOPE_W-1:0] slope;
		logic signed [ICPT_W-1:0]  icpt;
		logic signed [CB-1:0]      sl;
		logic signed [CB-1:0]      sr;
		logic signed [CB-1:0]      px;
	} request_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MODE_MAX;
	logic [CB-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = REQ_ADD;
	logic signed [SLOPE_W-1:0] line_slope = '0;
	logic signed [ICPT_W-1:0] line_intercept = '0;
	logic signed [CB-1:0] seg_left = '0;
	logic signed [CB-1:0] seg_right = '0;
	logic signed [CB-1:0] point_x = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [RESULT_W-1:0] best_value;

	always #6 clk = ~clk;

	li_chao_line_envelope_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .line_slope(line_slope), .line_intercept(line_intercept),
		.seg_left(seg_left), .seg_right(seg_right), .point_x(point_x),
		.out_valid(out_valid), .out_ready(out_ready), .best_value(best_value)
	);

	// Private copy of the tree and of the registers.
	logic signed [SLOPE_W-1:0] tree_slope [NC];
	logic signed [ICPT_W-1:0]  tree_icpt [NC];
	bit                        tree_valid [NC];
	bit                        keep_max;
	longint                    dom_lo, dom_hi;

	request_t pending_requests[$];
	longint   expected_values[$];

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int errors = 0;
	int results_seen = 0;
	int queries_seen = 0;
	int quiet_cycles = 0;

	// Set at the rising edge when a request is taken; read by the driver
	// on the falling edge.
	bit accepted_in = 0;

	function automatic longint empty_value();
		return keep_max ? -SENT : SENT;
	endfunction

	function automatic bit beats(longint a, longint b);
		return keep_max ? (a > b) : (a < b);
	endfunction

	function automatic longint half_point(longint l, longint r);
		return l + (r - l) / 2;
	endfunction

	function automatic void store_line(int idx, longint s, longint c);
		tree_slope[idx] = s;
		tree_icpt[idx] = c;
		tree_valid[idx] = 1'b1;
	endfunction

	function automatic void push_down_line(int idx, longint s, longint c,
			longint l, longint r);
		longint m, os, oc;
		bit win_l, win_m;
		while (idx < NC) begin
			if (!tree_valid[idx]) begin
				store_line(idx, s, c);
				return;
			end
			m = half_point(l, r);
			os = tree_slope[idx];
			oc = tree_icpt[idx];
			win_l = beats(s * l + c, os * l + oc);
			win_m = beats(s * m + c, os * m + oc);
			if (win_m) begin
				store_line(idx, s, c);
				s = os;
				c = oc;
			end
			if (l == r)
				return;
			if (win_l != win_m) begin
				idx = idx * 2;
				r = m;
			end else begin
				idx = idx * 2 + 1;
				l = m + 1;
			end
		end
	endfunction

	function automatic void place_segment_line(int idx, longint s, longint c,
			longint l, longint r, longint ql, longint qr);
		longint m;
		if (idx >= NC || l > qr || r < ql)
			return;
		if (l >= ql && r <= qr) begin
			push_down_line(idx, s, c, l, r);
			return;
		end
		// A partly covered empty node gets a flat line at the empty value.
		if (!tree_valid[idx])
			store_line(idx, 0, empty_value());
		m = half_point(l, r);
		place_segment_line(idx * 2, s, c, l, m, ql, qr);
		place_segment_line(idx * 2 + 1, s, c, m + 1, r, ql, qr);
	endfunction

	function automatic longint envelope_at(longint x);
		int idx = 1;
		longint l = dom_lo;
		longint r = dom_hi;
		longint acc = 0;
		longint v, m;
		bit have = 0;
		bit stop;
		forever begin
			stop = 0;
			if (idx >= NC || !tree_valid[idx]) begin
				v = empty_value();
				stop = 1;
			end else begin
				v = longint'(tree_slope[idx]) * x + longint'(tree_icpt[idx]);
			end
			if (!have || beats(v, acc))
				acc = v;
			have = 1;
			if (stop || l == r)
				break;
			m = half_point(l, r);
			if (x <= m) begin
				idx = idx * 2;
				r = m;
			end else begin
				idx = idx * 2 + 1;
				l = m + 1;
			end
		end
		return acc;
	endfunction

	// Applies one accepted request to the private tree; returns the answer.
	function automatic longint apply_request(request_t q);
		longint answer = 0;
		case (q.kind)
			REQ_ADD: begin
				if (dom_lo <= dom_hi)
					push_down_line(1, q.slope, q.icpt, dom_lo, dom_hi);
			end
			REQ_SEG: begin
				if (dom_lo <= dom_hi)
					place_segment_line(1, q.slope, q.icpt, dom_lo, dom_hi, q.sl, q.sr);
			end
			REQ_QUERY: begin
				answer = (dom_lo <= dom_hi) ? envelope_at(q.px) : empty_value();
			end
			default: begin
				foreach (tree_valid[i])
					tree_valid[i] = 1'b0;
			end
		endcase
		return answer;
	endfunction

	// Driver: the payload changes on the falling edge only after acceptance,
	// so valid stays high with a steady payload until the handshake completes.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || accepted_in) begin
				if (pending_requests.size() != 0 &&
						$urandom_range(99) >= sender_idle_pct) begin
					request_t q;
					q = pending_requests.pop_front();
					in_valid <= 1'b1;
					req_type <= q.kind;
					line_slope <= q.slope;
					line_intercept <= q.icpt;
					seg_left <= q.sl;
					seg_right <= q.sr;
					point_x <= q.px;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Monitor: predicts on each accepted request and checks each result.
	always @(posedge clk) begin
		accepted_in <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				request_t q;
				q = '{req_type, line_slope, line_intercept, seg_left, seg_right, point_x};
				expected_values.push_back(apply_request(q));
				if (q.kind == REQ_QUERY)
					queries_seen++;
			end
			if (out_valid && out_ready) begin
				longint want;
				results_seen++;
				if (expected_values.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, actual %0d", $time, best_value);
				end else begin
					want = expected_values.pop_front();
					if (longint'(best_value) != want) begin
						errors++;
						$display("%0t: best_value mismatch, expected %0d actual %0d",
							$time, want, best_value);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Watchdog: covers the clearing pass plus the slowest request and stalls.
	always @(posedge clk) begin
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Register write at the falling edge, mirrored in the private copy.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, longint value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CB-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_MODE_MAX:   keep_max = value[0];
			CFG_DOMAIN_LOW: dom_lo = longint'(signed'(value[CB-1:0]));
			default:        dom_hi = longint'(signed'(value[CB-1:0]));
		endcase
	endtask

	function automatic request_t make_request(logic [REQ_W-1:0] kind, longint s,
			longint c, longint l, longint r, longint x);
		request_t q;
		q.kind = kind;
		q.slope = s;
		q.icpt = c;
		q.sl = l;
		q.sr = r;
		q.px = x;
		return q;
	endfunction

	function automatic longint any_coord();
		return longint'($urandom_range(1023)) - 512;
	endfunction

	// Random request mix: mostly adds, segment adds and queries, some clears.
	function automatic request_t random_request();
		int pick = $urandom_range(99);
		logic [REQ_W-1:0] kind;
		longint s, c;
		if (pick < 30)
			kind = REQ_ADD;
		else if (pick < 50)
			kind = REQ_SEG;
		else if (pick < 97)
			kind = REQ_QUERY;
		else
			kind = REQ_CLEAR;
		// Mix extreme and small line values.
		s = ($urandom_range(3) == 0) ? longint'(signed'(16'($urandom())))
			: longint'($urandom_range(200)) - 100;
		c = ($urandom_range(3) == 0) ? longint'(signed'(32'($urandom())))
			: longint'($urandom_range(200000)) - 100000;
		return make_request(kind, s, c, any_coord(), any_coord(), any_coord());
	endfunction

	// Waits until every queued request has been taken and answered, plus a
	// margin for the clear sweep of the block.
	task automatic drain();
		int guard = 0;
		while ((pending_requests.size() != 0 || in_valid ||
				expected_values.size() != 0) && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (NC + 100) @(posedge clk);
	endtask

	initial begin
		int phase;
		keep_max = 0;
		dom_lo = -512;
		dom_hi = 511;
		foreach (tree_valid[i])
			tree_valid[i] = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty tree, extreme lines, segments, inverted segment,
		// queries at the domain edges, clear.
		pending_requests.push_back(make_request(REQ_QUERY, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(REQ_ADD, -32768, -2147483648, 0, 0, 0));
		pending_requests.push_back(make_request(REQ_ADD, 32767, 2147483647, 0, 0, 0));
		pending_requests.push_back(make_request(REQ_QUERY, 0, 0, 0, 0, -512));
		pending_requests.push_back(make_request(REQ_QUERY, 0, 0, 0, 0, 511));
		pending_requests.push_back(make_request(REQ_SEG, 5, -7, -100, 37, 0));
		pending_requests.push_back(make_request(REQ_SEG, -3, 9, 50, -50, 0));
		pending_requests.push_back(make_request(REQ_SEG, 1, 1, -512, 511, 0));
		pending_requests.push_back(make_request(REQ_QUERY, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(REQ_QUERY, 0, 0, 0, 0, -1));
		pending_requests.push_back(make_request(REQ_CLEAR, 0, 0, 0, 0, 0));
		pending_requests.push_back(make_request(REQ_QUERY, 0, 0, 0, 0, 3));
		drain();

		// Phases with different registers and idle patterns; extremes included.
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
				default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
			endcase
			write_register(CFG_MODE_MAX, phase % 2);
			case (phase)
				0: begin write_register(CFG_DOMAIN_LOW, -512); write_register(CFG_DOMAIN_HIGH, 511); end
				1: begin write_register(CFG_DOMAIN_LOW, -20);  write_register(CFG_DOMAIN_HIGH, 30);  end
				2: begin write_register(CFG_DOMAIN_LOW, 7);    write_register(CFG_DOMAIN_HIGH, 7);   end
				3: begin write_register(CFG_DOMAIN_LOW, 100);  write_register(CFG_DOMAIN_HIGH, -100); end
				4: begin write_register(CFG_DOMAIN_LOW, 511);  write_register(CFG_DOMAIN_HIGH, 511); end
				5: begin write_register(CFG_DOMAIN_LOW, -512); write_register(CFG_DOMAIN_HIGH, -512); end
				default: begin
					write_register(CFG_DOMAIN_LOW, any_coord() / 2 - 256);
					write_register(CFG_DOMAIN_HIGH, any_coord() / 2 + 256);
				end
			endcase
			// The mode flips between phases while lines stay stored.
			repeat (80)
				pending_requests.push_back(random_request());
			drain();
		end

		$display("Ran %0d results (%0d queries) over 8 register settings and four",
			results_seen, queries_seen);
		$display("idle patterns, including inverted and one-point domains.");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
